### sv/lmbs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lmbs_pkg: shared types, constants and helpers of the LED matrix scan block
// Holds the frame store geometry, field widths, register indexes, item kinds
// and the clamping and address functions used by the scan and store logic.
// ============================================================================
package lmbs_pkg;

    // Frame store geometry
    localparam int PLANES          = 11;
    localparam int MAX_COLUMNS     = 128;
    localparam int MAX_DOUBLE_ROWS = 16;
    localparam int STORE_DEPTH     = MAX_DOUBLE_ROWS * PLANES * MAX_COLUMNS;
    localparam int STORE_AW        = $clog2(STORE_DEPTH);

    // Field widths
    localparam int ROW_W    = 4;
    localparam int PLANE_W  = 4;
    localparam int COL_W    = $clog2(MAX_COLUMNS);
    localparam int COLOUR_W = 6;
    localparam int RP_W     = STORE_AW - COL_W;

    // Configuration register widths
    localparam int SHOWN_W     = 4;
    localparam int ROWS_W      = 5;
    localparam int COLS_W      = 8;
    localparam int BASE_W      = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int ONTIME_W    = BASE_W + PLANES - 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHOWN_PLANES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_ROW_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_TICKS       = 2'd3;

    // Configuration reset values
    localparam logic [SHOWN_W-1:0] SHOWN_RESET = 4'd11;
    localparam logic [ROWS_W-1:0]  ROWS_RESET  = 5'd16;
    localparam logic [COLS_W-1:0]  COLS_RESET  = 8'd32;
    localparam logic [BASE_W-1:0]  BASE_RESET  = 10'd100;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Configuration registers as seen by the scan sequencer
    typedef struct packed {
        logic [SHOWN_W-1:0] shown_planes;
        logic [ROWS_W-1:0]  double_row_count;
        logic [COLS_W-1:0]  column_count;
        logic [BASE_W-1:0]  base_ticks;
    } t_cfg;

    // Panel pin levels; from_ram selects the store read data for the colours
    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [COLOUR_W-1:0] colour;
        logic                from_ram;
        logic                clk;
        logic                latch;
        logic                blank;
    } t_pins;

    // Frame store read request from the scan sequencer
    typedef struct packed {
        logic               en;
        logic [ROW_W-1:0]   row;
        logic [PLANE_W-1:0] plane;
        logic [COL_W-1:0]   col;
    } t_rd_req;

    // Shown planes clamped to one through PLANES.
    function automatic logic [SHOWN_W-1:0] eff_planes(input logic [SHOWN_W-1:0] v);
        logic [SHOWN_W-1:0] r;
        if (v == '0) begin
            r = SHOWN_W'(1);
        end else if (v > SHOWN_W'(PLANES)) begin
            r = SHOWN_W'(PLANES);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Double row count clamped to one through MAX_DOUBLE_ROWS.
    function automatic logic [ROWS_W-1:0] eff_rows(input logic [ROWS_W-1:0] v);
        logic [ROWS_W-1:0] r;
        if (v == '0) begin
            r = ROWS_W'(1);
        end else if (v > ROWS_W'(MAX_DOUBLE_ROWS)) begin
            r = ROWS_W'(MAX_DOUBLE_ROWS);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Column count clamped to one through MAX_COLUMNS.
    function automatic logic [COLS_W-1:0] eff_cols(input logic [COLS_W-1:0] v);
        logic [COLS_W-1:0] r;
        if (v == '0) begin
            r = COLS_W'(1);
        end else if (v > COLS_W'(MAX_COLUMNS)) begin
            r = COLS_W'(MAX_COLUMNS);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Base ticks with zero acting as one.
    function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] v);
        return (v == '0) ? BASE_W'(1) : v;
    endfunction

    // Linear store address: (row * PLANES + plane) * MAX_COLUMNS + column.
    function automatic logic [STORE_AW-1:0] store_addr(
        input logic [ROW_W-1:0]   row,
        input logic [PLANE_W-1:0] plane,
        input logic [COL_W-1:0]   col
    );
        logic [RP_W-1:0] rp;
        rp = RP_W'(row) * RP_W'(PLANES) + RP_W'(plane);
        return {rp, col};
    endfunction

endpackage

### sv/lmbs_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// lmbs_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; the read data is registered and holds
// its value until the next read.
// ============================================================================
module lmbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/lmbs_store.sv
`timescale 1ns / 1ps
// ============================================================================
// lmbs_store: bit-plane frame store with a clearing pass after reset
// Maps row, plane and column to a linear address, drops writes to planes
// outside the store, and zeroes every entry once after reset.
// ============================================================================
module lmbs_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [lmbs_pkg::ROW_W-1:0]    i_wr_row,
    input  logic [lmbs_pkg::PLANE_W-1:0]  i_wr_plane,
    input  logic [lmbs_pkg::COL_W-1:0]    i_wr_col,
    input  logic [lmbs_pkg::COLOUR_W-1:0] i_wr_colours,
    input  lmbs_pkg::t_rd_req             i_rd,
    output logic [lmbs_pkg::COLOUR_W-1:0] o_rdata,
    output logic                          o_busy
);

    logic                              r_clr_busy;
    logic [lmbs_pkg::STORE_AW-1:0]     r_clr_addr;
    logic                              ram_we;
    logic [lmbs_pkg::STORE_AW-1:0]     ram_waddr;
    logic [lmbs_pkg::COLOUR_W-1:0]     ram_wdata;
    logic [lmbs_pkg::STORE_AW-1:0]     ram_raddr;
    logic                              wr_in_range;

    // Clearing pass: one entry per cycle from address zero to the last entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == lmbs_pkg::STORE_AW'(lmbs_pkg::STORE_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Write port: the clearing pass owns it while busy, items afterwards.
    // Planes beyond the store are ignored.
    assign wr_in_range = (i_wr_plane < lmbs_pkg::PLANE_W'(lmbs_pkg::PLANES));

    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = i_wr && wr_in_range;
            ram_waddr = lmbs_pkg::store_addr(i_wr_row, i_wr_plane, i_wr_col);
            ram_wdata = i_wr_colours;
        end
    end

    // Items are taken at most one per cycle, so a read never meets a write in the
    // same cycle; a read right after a write to the same entry sees new data.
    assign ram_raddr = lmbs_pkg::store_addr(i_rd.row, i_rd.plane, i_rd.col);

    lmbs_ram #(
        .WIDTH (lmbs_pkg::COLOUR_W),
        .DEPTH (lmbs_pkg::STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_rd.en),
        .i_raddr (ram_raddr),
        .o_rdata (o_rdata)
    );

    assign o_busy = r_clr_busy;

    // Checks
    a_no_read_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_rd.en)
        else $error("store read during clearing pass");

    a_no_item_write_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_wr)
        else $error("item write during clearing pass");

    a_clear_ends_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clr_busy |=> !r_clr_busy)
        else $error("clearing pass restarted without reset");

endmodule

### sv/lmbs_scan.sv
`timescale 1ns / 1ps
// ============================================================================
// lmbs_scan: panel scan sequencer
// Steps through row setup, column shifting, latch and the binary weighted
// on-time of each plane, one pin update per scan tick, and issues the frame
// store read for each data tick.
// ============================================================================
module lmbs_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  lmbs_pkg::t_cfg     i_cfg,
    output lmbs_pkg::t_pins    o_pins,
    output lmbs_pkg::t_rd_req  o_rd
);

    localparam int PH_W = 3;
    localparam logic [PH_W-1:0] PH_ROW      = 3'd0;
    localparam logic [PH_W-1:0] PH_DATA     = 3'd1;
    localparam logic [PH_W-1:0] PH_CLOCK    = 3'd2;
    localparam logic [PH_W-1:0] PH_CLEAR    = 3'd3;
    localparam logic [PH_W-1:0] PH_LATCH_HI = 3'd4;
    localparam logic [PH_W-1:0] PH_LATCH_LO = 3'd5;
    localparam logic [PH_W-1:0] PH_LIGHT    = 3'd6;
    localparam logic [PH_W-1:0] PH_HOLD     = 3'd7;

    localparam logic [lmbs_pkg::PLANE_W-1:0] PLANE_RESET =
        lmbs_pkg::PLANE_W'(lmbs_pkg::PLANES) - lmbs_pkg::eff_planes(lmbs_pkg::SHOWN_RESET);

    logic [PH_W-1:0]                 r_phase,  n_phase;
    logic [lmbs_pkg::ROW_W-1:0]      r_row,    n_row;
    logic [lmbs_pkg::PLANE_W-1:0]    r_plane,  n_plane;
    logic [lmbs_pkg::COL_W-1:0]      r_col,    n_col;
    logic [lmbs_pkg::ONTIME_W-1:0]   r_ontime, n_ontime;
    lmbs_pkg::t_pins                 r_pins,   n_pins;

    logic [lmbs_pkg::COLS_W-1:0]     col_next;
    logic [lmbs_pkg::ROWS_W-1:0]     row_next;
    logic [lmbs_pkg::PLANE_W:0]      plane_next;

    assign col_next   = lmbs_pkg::COLS_W'(r_col) + 1'b1;
    assign row_next   = lmbs_pkg::ROWS_W'(r_row) + 1'b1;
    assign plane_next = {1'b0, r_plane} + 1'b1;

    // Next scan state for one tick.
    always_comb begin
        n_phase  = r_phase;
        n_row    = r_row;
        n_plane  = r_plane;
        n_col    = r_col;
        n_ontime = r_ontime;
        n_pins   = r_pins;
        o_rd.en    = 1'b0;
        o_rd.row   = r_row;
        o_rd.plane = r_plane;
        o_rd.col   = r_col;
        if (i_tick) begin
            case (r_phase)
                PH_ROW: begin
                    n_pins.row = r_row;
                    n_col      = '0;
                    n_phase    = PH_DATA;
                end
                PH_DATA: begin
                    // Colours come from the registered store read data.
                    o_rd.en         = 1'b1;
                    n_pins.from_ram = 1'b1;
                    n_pins.clk      = 1'b0;
                    n_phase         = PH_CLOCK;
                end
                PH_CLOCK: begin
                    n_pins.clk = 1'b1;
                    if (col_next >= lmbs_pkg::eff_cols(i_cfg.column_count)) begin
                        n_phase = PH_CLEAR;
                    end else begin
                        n_col   = col_next[lmbs_pkg::COL_W-1:0];
                        n_phase = PH_DATA;
                    end
                end
                PH_CLEAR: begin
                    n_pins.colour   = '0;
                    n_pins.from_ram = 1'b0;
                    n_pins.clk      = 1'b0;
                    n_col           = '0;
                    n_phase         = PH_LATCH_HI;
                end
                PH_LATCH_HI: begin
                    n_pins.latch = 1'b1;
                    n_phase      = PH_LATCH_LO;
                end
                PH_LATCH_LO: begin
                    n_pins.latch = 1'b0;
                    n_phase      = PH_LIGHT;
                end
                PH_LIGHT: begin
                    // The blank-low tick counts as the first lit tick.
                    n_pins.blank = 1'b0;
                    n_ontime     = lmbs_pkg::ONTIME_W'(lmbs_pkg::eff_base(i_cfg.base_ticks))
                                   << r_plane;
                    n_phase      = PH_HOLD;
                end
                PH_HOLD: begin
                    if (r_ontime > lmbs_pkg::ONTIME_W'(1)) begin
                        n_ontime = r_ontime - 1'b1;
                    end else begin
                        n_ontime     = '0;
                        n_pins.blank = 1'b1;
                        n_col        = '0;
                        if (plane_next < (lmbs_pkg::PLANE_W + 1)'(lmbs_pkg::PLANES)) begin
                            n_plane = plane_next[lmbs_pkg::PLANE_W-1:0];
                            n_phase = PH_DATA;
                        end else begin
                            // Last plane of the row: move to the next double row.
                            if (row_next >= lmbs_pkg::eff_rows(i_cfg.double_row_count)) begin
                                n_row = '0;
                            end else begin
                                n_row = row_next[lmbs_pkg::ROW_W-1:0];
                            end
                            n_plane = lmbs_pkg::PLANE_W'(lmbs_pkg::PLANES)
                                      - lmbs_pkg::eff_planes(i_cfg.shown_planes);
                            n_phase = PH_ROW;
                        end
                    end
                end
                default: begin
                    n_phase = PH_ROW;
                end
            endcase
        end
    end

    // Scan state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_ROW;
            r_row         <= '0;
            r_plane       <= PLANE_RESET;
            r_col         <= '0;
            r_ontime      <= '0;
            r_pins        <= '0;
            r_pins.blank  <= 1'b1;
        end else begin
            r_phase  <= n_phase;
            r_row    <= n_row;
            r_plane  <= n_plane;
            r_col    <= n_col;
            r_ontime <= n_ontime;
            r_pins   <= n_pins;
        end
    end

    // Pin levels after the current item.
    assign o_pins = n_pins;

    // Checks
    a_plane_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plane < lmbs_pkg::PLANE_W'(lmbs_pkg::PLANES))
        else $error("plane counter beyond the store");

    a_latch_while_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pins.latch |-> r_pins.blank)
        else $error("latch pulsed while LEDs are lit");

    a_lit_means_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pins.blank |-> (!r_pins.clk && !r_pins.from_ram && r_pins.colour == '0))
        else $error("shift lines active while LEDs are lit");

    a_hold_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HOLD) |-> (r_ontime != '0))
        else $error("on-time hold with an empty counter");

endmodule

### sv/led_matrix_bitplane_scan_top.sv
`timescale 1ns / 1ps
// ============================================================================
// led_matrix_bitplane_scan_top: bit-plane scan driver for a two-half RGB panel
// Stores six colour bits per double row, plane and column and produces the
// panel pin levels, one pin update per scan tick item.
// ============================================================================
// Usage:
//   The input channel (i_valid / o_stall) takes items of two kinds: a write
//   item loads one frame store entry unless its plane is beyond the store,
//   a tick item advances the scan by one pin update. Each item gives exactly
//   one result on the output channel (o_valid / i_stall): the pin levels
//   after that item, captured in the output register.
//   Throughput is one item per cycle while the receiver does not stall; the
//   output register is refilled in the same cycle that its result is taken.
//   The frame store has one read port, used by the data tick of each column,
//   and one write port, used by write items, so the two never compete.
//   After reset the block clears every frame store entry, one entry per
//   cycle; o_stall stays high during that pass. Configuration writes are
//   taken at any time and should be made while the block is idle.
//   While the receiver stalls, the result holds and o_stall rises, so no
//   item is lost or repeated.
// ============================================================================
module led_matrix_bitplane_scan_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [lmbs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lmbs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_kind,
    input  logic [lmbs_pkg::ROW_W-1:0]            i_write_row,
    input  logic [lmbs_pkg::PLANE_W-1:0]          i_write_plane,
    input  logic [lmbs_pkg::COL_W-1:0]            i_write_column,
    input  logic [lmbs_pkg::COLOUR_W-1:0]         i_write_colours,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [lmbs_pkg::ROW_W-1:0]            o_row_address,
    output logic [lmbs_pkg::COLOUR_W-1:0]         o_colour_pins,
    output logic                                  o_shift_clock,
    output logic                                  o_latch_pin,
    output logic                                  o_blank_pin
);

    lmbs_pkg::t_cfg                  r_cfg;
    lmbs_pkg::t_pins                 r_out_pins;
    logic                            r_out_valid;
    lmbs_pkg::t_pins                 scan_pins;
    lmbs_pkg::t_rd_req               scan_rd;
    logic [lmbs_pkg::COLOUR_W-1:0]   store_rdata;
    logic                            store_busy;
    logic                            in_acc;
    logic                            tick_acc;
    logic                            write_acc;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shown_planes     <= lmbs_pkg::SHOWN_RESET;
            r_cfg.double_row_count <= lmbs_pkg::ROWS_RESET;
            r_cfg.column_count     <= lmbs_pkg::COLS_RESET;
            r_cfg.base_ticks       <= lmbs_pkg::BASE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lmbs_pkg::CFG_SHOWN_PLANES:
                    r_cfg.shown_planes <= i_cfg_data[lmbs_pkg::SHOWN_W-1:0];
                lmbs_pkg::CFG_DOUBLE_ROW_COUNT:
                    r_cfg.double_row_count <= i_cfg_data[lmbs_pkg::ROWS_W-1:0];
                lmbs_pkg::CFG_COLUMN_COUNT:
                    r_cfg.column_count <= i_cfg_data[lmbs_pkg::COLS_W-1:0];
                lmbs_pkg::CFG_BASE_TICKS:
                    r_cfg.base_ticks <= i_cfg_data[lmbs_pkg::BASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input handshake: hold off during the clearing pass or a stalled result.
    assign o_stall   = store_busy || (r_out_valid && i_stall);
    assign in_acc    = i_valid && !o_stall;
    assign tick_acc  = in_acc && (i_kind == lmbs_pkg::KIND_TICK);
    assign write_acc = in_acc && (i_kind == lmbs_pkg::KIND_WRITE);

    lmbs_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_acc),
        .i_cfg   (r_cfg),
        .o_pins  (scan_pins),
        .o_rd    (scan_rd)
    );

    lmbs_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (write_acc),
        .i_wr_row     (i_write_row),
        .i_wr_plane   (i_write_plane),
        .i_wr_col     (i_write_column),
        .i_wr_colours (i_write_colours),
        .i_rd         (scan_rd),
        .o_rdata      (store_rdata),
        .o_busy       (store_busy)
    );

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_pins <= scan_pins;
        end
    end

    // The store read data holds until the next data tick, which cannot be
    // accepted while this result is still waiting.
    assign o_valid       = r_out_valid;
    assign o_row_address = r_out_pins.row;
    assign o_colour_pins = r_out_pins.from_ram ? store_rdata : r_out_pins.colour;
    assign o_shift_clock = r_out_pins.clk;
    assign o_latch_pin   = r_out_pins.latch;
    assign o_blank_pin   = r_out_pins.blank;

    // Checks
    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_busy |-> !r_out_valid)
        else $error("result present during clearing pass");

    a_data_tick_reads_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_rd.en |-> (tick_acc && scan_pins.from_ram))
        else $error("store read without an accepted data tick");

    a_write_keeps_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (write_acc && r_out_valid) |=> (r_out_pins == $past(scan_pins)))
        else $error("write item result lost the current pin levels");

endmodule

### tb/tb_led_matrix_bitplane_scan_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_led_matrix_bitplane_scan_top: self-checking bench for the LED panel scan
// Sends frame store writes and scan ticks through the valid/stall channel,
// predicts the panel pin levels that each item leaves behind with a local
// model of the scan sequencer and frame store, and compares every result
// field by field. Random idling on both sides, a long receiver hold-off and
// several register settings, the extremes among them, are exercised.
// ============================================================================
module tb_led_matrix_bitplane_scan_top;
    import lmbs_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_ITEMS     = 180;

    // Steps of the scan sequencer, in the order a plane walks through them.
    typedef enum logic [3:0] {
        SCAN_ROW,
        SCAN_DATA,
        SCAN_CLOCK,
        SCAN_CLEAR,
        SCAN_LATCH_HI,
        SCAN_LATCH_LO,
        SCAN_LIGHT,
        SCAN_HOLD
    } scan_phase_e;

    // Pin levels as they appear on the result channel.
    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [COLOUR_W-1:0] colour;
        logic                clk;
        logic                latch;
        logic                blank;
    } panel_pins_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_kind;
    logic [ROW_W-1:0]      i_write_row;
    logic [PLANE_W-1:0]    i_write_plane;
    logic [COL_W-1:0]      i_write_column;
    logic [COLOUR_W-1:0]   i_write_colours;
    logic                  o_valid;
    logic                  i_stall;
    logic [ROW_W-1:0]      o_row_address;
    logic [COLOUR_W-1:0]   o_colour_pins;
    logic                  o_shift_clock;
    logic                  o_latch_pin;
    logic                  o_blank_pin;

    led_matrix_bitplane_scan_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_write_row     (i_write_row),
        .i_write_plane   (i_write_plane),
        .i_write_column  (i_write_column),
        .i_write_colours (i_write_colours),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_row_address   (o_row_address),
        .o_colour_pins   (o_colour_pins),
        .o_shift_clock   (o_shift_clock),
        .o_latch_pin     (o_latch_pin),
        .o_blank_pin     (o_blank_pin)
    );

    // Local copy of the frame store, the registers and the sequencer state.
    logic [COLOUR_W-1:0] pixel_store [STORE_DEPTH];
    logic [SHOWN_W-1:0]  cf_shown;
    logic [ROWS_W-1:0]   cf_rows;
    logic [COLS_W-1:0]   cf_cols;
    logic [BASE_W-1:0]   cf_base;
    scan_phase_e         sc_phase;
    logic [ROW_W-1:0]    sc_row;
    logic [PLANE_W-1:0]  sc_plane;
    logic [COL_W-1:0]    sc_col;
    logic [ONTIME_W-1:0] sc_on_time;
    panel_pins_t         sc_pins;

    panel_pins_t expected_pins [$];

    int  error_count     = 0;
    int  results_checked = 0;
    int  writes_sent     = 0;
    int  ticks_sent      = 0;
    int  cfg_writes      = 0;
    int  rows_started    = 0;
    int  cycle_count     = 0;
    bit  idle_on         = 1'b1;
    bit  hold_off_req    = 1'b0;

    // 8 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // A register value of zero counts as one; anything above the limit is the limit.
    function automatic int clamp_count(input int value, input int limit);
        if (value == 0) begin
            return 1;
        end else if (value > limit) begin
            return limit;
        end
        return value;
    endfunction

    task automatic reset_scan_model();
        foreach (pixel_store[i]) begin
            pixel_store[i] = '0;
        end
        cf_shown   = SHOWN_RESET;
        cf_rows    = ROWS_RESET;
        cf_cols    = COLS_RESET;
        cf_base    = BASE_RESET;
        sc_phase   = SCAN_ROW;
        sc_row     = '0;
        sc_plane   = PLANE_W'(PLANES - clamp_count(int'(cf_shown), PLANES));
        sc_col     = '0;
        sc_on_time = '0;
        sc_pins    = '{row: '0, colour: '0, clk: 1'b0, latch: 1'b0, blank: 1'b1};
    endtask

    // Applies one item to the local scan state and returns the pin levels after it.
    function automatic panel_pins_t pins_after_item(
        input logic                kind,
        input logic [ROW_W-1:0]    wrow,
        input logic [PLANE_W-1:0]  wplane,
        input logic [COL_W-1:0]    wcol,
        input logic [COLOUR_W-1:0] wcolours
    );
        int addr;
        if (kind == KIND_WRITE) begin
            // Row and column always fit the store; planes past the last are dropped.
            if (int'(wplane) < PLANES) begin
                addr = (int'(wrow) * PLANES + int'(wplane)) * MAX_COLUMNS + int'(wcol);
                pixel_store[addr] = wcolours;
            end
            return sc_pins;
        end
        case (sc_phase)
            SCAN_ROW: begin
                sc_pins.row = sc_row;
                sc_col      = '0;
                sc_phase    = SCAN_DATA;
                rows_started++;
            end
            SCAN_DATA: begin
                addr = (int'(sc_row) * PLANES + int'(sc_plane)) * MAX_COLUMNS + int'(sc_col);
                sc_pins.colour = pixel_store[addr];
                sc_pins.clk    = 1'b0;
                sc_phase       = SCAN_CLOCK;
            end
            SCAN_CLOCK: begin
                sc_pins.clk = 1'b1;
                // A column counter already past a lowered count ends the plane here.
                if (int'(sc_col) + 1 >= clamp_count(int'(cf_cols), MAX_COLUMNS)) begin
                    sc_phase = SCAN_CLEAR;
                end else begin
                    sc_col++;
                    sc_phase = SCAN_DATA;
                end
            end
            SCAN_CLEAR: begin
                sc_pins.colour = '0;
                sc_pins.clk    = 1'b0;
                sc_col         = '0;
                sc_phase       = SCAN_LATCH_HI;
            end
            SCAN_LATCH_HI: begin
                sc_pins.latch = 1'b1;
                sc_phase      = SCAN_LATCH_LO;
            end
            SCAN_LATCH_LO: begin
                sc_pins.latch = 1'b0;
                sc_phase      = SCAN_LIGHT;
            end
            SCAN_LIGHT: begin
                sc_pins.blank = 1'b0;
                sc_on_time    = ONTIME_W'(clamp_count(int'(cf_base), 1023)) << sc_plane;
                sc_phase      = SCAN_HOLD;
            end
            default: begin
                // The blank-low tick was the first lit one, so stop at one.
                if (sc_on_time > 1) begin
                    sc_on_time--;
                end else begin
                    sc_on_time    = '0;
                    sc_pins.blank = 1'b1;
                    sc_plane++;
                    sc_col = '0;
                    if (int'(sc_plane) < PLANES) begin
                        sc_phase = SCAN_DATA;
                    end else begin
                        if (int'(sc_row) + 1 >= clamp_count(int'(cf_rows), MAX_DOUBLE_ROWS)) begin
                            sc_row = '0;
                        end else begin
                            sc_row++;
                        end
                        sc_plane = PLANE_W'(PLANES - clamp_count(int'(cf_shown), PLANES));
                        sc_phase = SCAN_ROW;
                    end
                end
            end
        endcase
        return sc_pins;
    endfunction

    // Sends one item, with a random gap in front when idling is on.
    task automatic send_item(
        input logic                kind,
        input logic [ROW_W-1:0]    wrow,
        input logic [PLANE_W-1:0]  wplane,
        input logic [COL_W-1:0]    wcol,
        input logic [COLOUR_W-1:0] wcolours
    );
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= kind;
        i_write_row     <= wrow;
        i_write_plane   <= wplane;
        i_write_column  <= wcol;
        i_write_colours <= wcolours;
        @(posedge i_clk);
        while (o_stall !== 1'b0) begin
            @(posedge i_clk);
        end
        expected_pins.push_back(pins_after_item(kind, wrow, wplane, wcol, wcolours));
        if (kind == KIND_WRITE) begin
            writes_sent++;
        end else begin
            ticks_sent++;
        end
    endtask

    // A tick carries random write fields, which the block must ignore.
    task automatic send_tick();
        send_item(KIND_TICK, ROW_W'($urandom), PLANE_W'($urandom), COL_W'($urandom),
                  COLOUR_W'($urandom));
    endtask

    // Stops offering items and waits until every expected result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_pins.size() != 0);
    endtask

    // Writes all four registers; only called while nothing is in flight.
    task automatic configure(
        input logic [SHOWN_W-1:0] shown,
        input logic [ROWS_W-1:0]  rows,
        input logic [COLS_W-1:0]  cols,
        input logic [BASE_W-1:0]  base
    );
        logic [CFG_IDX_W-1:0]  reg_idx [4];
        logic [CFG_DATA_W-1:0] reg_val [4];
        reg_idx = '{CFG_SHOWN_PLANES, CFG_DOUBLE_ROW_COUNT, CFG_COLUMN_COUNT, CFG_BASE_TICKS};
        reg_val = '{CFG_DATA_W'(shown), CFG_DATA_W'(rows), CFG_DATA_W'(cols),
                    CFG_DATA_W'(base)};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= reg_idx[i];
            i_cfg_data <= reg_val[i];
            @(posedge i_clk);
            cfg_writes++;
        end
        i_cfg_we <= 1'b0;
        cf_shown = shown;
        cf_rows  = rows;
        cf_cols  = cols;
        cf_base  = base;
        @(posedge i_clk);
    endtask

    task automatic ticks_until_phase(input scan_phase_e target);
        while (sc_phase != target) begin
            send_tick();
        end
    endtask

    task automatic ticks_until_row_start(input int count);
        int target;
        target = rows_started + count;
        while (rows_started < target) begin
            send_tick();
        end
    endtask

    // Reset values: row zero, blank high, cleared store, scan from plane zero.
    task automatic test_reset_state();
        idle_on = 1'b1;
        repeat (8) send_tick();
        drain_results();
    endtask

    // Store extremes, dropped planes, and a column count cut below the counter.
    task automatic test_directed_entries();
        idle_on = 1'b1;
        configure(4'd15, 5'd2, 8'd3, 10'd0);
        send_item(KIND_WRITE, 4'd0, 4'd1, 7'd0, 6'h3F);
        send_item(KIND_WRITE, 4'd0, 4'd1, 7'd1, 6'h2A);
        send_item(KIND_WRITE, 4'd0, 4'd1, 7'd2, 6'h15);
        send_item(KIND_WRITE, 4'd15, 4'd10, 7'd127, 6'h3F);
        // Plane eleven would land on row one, plane zero if it were not dropped.
        send_item(KIND_WRITE, 4'd0, 4'd11, 7'd0, 6'h3F);
        send_item(KIND_WRITE, 4'd15, 4'd15, 7'd127, 6'h3F);
        send_item(KIND_WRITE, 4'd1, 4'd0, 7'd1, 6'h01);
        repeat (18) send_tick();
        drain_results();
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_output_backpressure();
        idle_on = 1'b0;
        configure(4'd11, 5'd0, 8'd2, 10'd1);
        hold_off_req = 1'b1;
        repeat (40) send_tick();
        drain_results();
    endtask

    // Random register settings with writes aimed mostly at the scanned row.
    task automatic test_random_scan();
        logic [ROW_W-1:0]   wrow;
        logic [PLANE_W-1:0] wplane;
        logic [COL_W-1:0]   wcol;
        logic [COLS_W-1:0]  cols;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            idle_on = (p != 2);
            cols = ($urandom_range(0, 4) == 0) ? COLS_W'($urandom_range(0, 255))
                                               : COLS_W'($urandom_range(0, 6));
            configure(SHOWN_W'($urandom_range(0, 15)), ROWS_W'($urandom_range(0, 31)), cols,
                      BASE_W'($urandom_range(0, 1)));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    wrow   = ($urandom_range(0, 2) != 0) ? sc_row : ROW_W'($urandom);
                    wplane = ($urandom_range(0, 1) != 0) ? sc_plane : PLANE_W'($urandom);
                    if ($urandom_range(0, 2) != 0) begin
                        wcol = COL_W'($urandom_range(0,
                                   clamp_count(int'(cf_cols), MAX_COLUMNS) - 1));
                    end else begin
                        wcol = COL_W'($urandom);
                    end
                    send_item(KIND_WRITE, wrow, wplane, wcol, COLOUR_W'($urandom));
                end else begin
                    send_tick();
                end
            end
            drain_results();
        end
    endtask

    // The sender stops until every result is back, then carries on.
    task automatic test_sender_pause();
        idle_on = 1'b1;
        repeat (15) send_tick();
        drain_results();
        repeat (15) send_tick();
        drain_results();
    endtask

    // One shown plane over two double rows, so the row address wraps.
    task automatic test_row_wrap();
        idle_on = 1'b0;
        configure(4'd0, 5'd2, 8'd1, 10'd1);
        ticks_until_row_start(3);
        drain_results();
    endtask

    // Largest base tick count on plane zero, then a full 128 column shift.
    task automatic test_long_hold();
        idle_on = 1'b0;
        configure(4'd11, 5'd31, 8'd0, 10'd1);
        ticks_until_row_start(1);
        drain_results();
        configure(4'd11, 5'd31, 8'd0, 10'd1023);
        ticks_until_phase(SCAN_HOLD);
        ticks_until_phase(SCAN_DATA);
        drain_results();
        configure(4'd11, 5'd31, 8'd128, 10'd1);
        ticks_until_phase(SCAN_CLEAR);
        drain_results();
    endtask

    task automatic check_pin(input string name, input logic [5:0] want, input logic [5:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Result checker: every accepted result against the oldest expectation.
    initial begin
        panel_pins_t want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
                if (expected_pins.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual %0h %0h %b%b%b",
                             $time, o_row_address, o_colour_pins, o_shift_clock,
                             o_latch_pin, o_blank_pin);
                    error_count++;
                end else begin
                    want = expected_pins.pop_front();
                    results_checked++;
                    check_pin("row_address", 6'(want.row), 6'(o_row_address));
                    check_pin("colour_pins", want.colour, o_colour_pins);
                    check_pin("shift_clock", 6'(want.clk), 6'(o_shift_clock));
                    check_pin("latch_pin", 6'(want.latch), 6'(o_latch_pin));
                    check_pin("blank_pin", 6'(want.blank), 6'(o_blank_pin));
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long counted hold-off on request.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_stall <= 1'b1;
                for (int n = 0; n < HOLD_OFF_CYCLES; n++) begin
                    @(posedge i_clk);
                end
                hold_off_req = 1'b0;
                i_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Run limit, generous against the store clearing pass and the slowest items.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                 expected_pins.size());
        $display("Some tests failed");
        $finish;
    end

    // Main sequence.
    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_SHOWN_PLANES;
        i_cfg_data      <= '0;
        i_valid         <= 1'b0;
        i_kind          <= KIND_TICK;
        i_write_row     <= '0;
        i_write_plane   <= '0;
        i_write_column  <= '0;
        i_write_colours <= '0;
        reset_scan_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_directed_entries();
        test_output_backpressure();
        test_random_scan();
        test_sender_pause();
        test_row_wrap();
        test_long_hold();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d results from %0d writes and %0d ticks in %0d cycles",
                 results_checked, writes_sent, ticks_sent, cycle_count);
        $display("Made %0d register writes; the scan started %0d double rows",
                 cfg_writes, rows_started);
        if (error_count == 0 && expected_pins.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
